// ===== src/tmg_pkg.sv =====
// Shared types and constants for the text-mode glyph row generator.
// No dependencies; every other file in src refers to this package by scoped names.
package tmg_pkg;

	// Request kinds carried in the input tuser bit.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_RENDER = 1'b1;

	// Double-byte code mapping: (high - 1) * 94 + (low - 1) + 256.
	localparam int unsigned CODES_PER_BANK   = 94;
	localparam int unsigned DOUBLE_BYTE_BASE = 256;

	// Field widths fixed by the beat layout.
	localparam int unsigned INDEX_W = 14;
	localparam int unsigned ROW_W   = 4;
	localparam int unsigned BITS_W  = 16;
	localparam int unsigned CELL_W  = 32;
	localparam int unsigned COLOR_W = 16;
	// Wide enough for any glyph number a code can produce and for 65536 glyphs.
	localparam int unsigned GLYPH_W = 16;

	// Input tdata layout, lowest bit first.
	localparam int unsigned IN_INDEX_LSB = 0;
	localparam int unsigned IN_ROW_LSB   = IN_INDEX_LSB + INDEX_W;
	localparam int unsigned IN_BITS_LSB  = IN_ROW_LSB + ROW_W;
	localparam int unsigned IN_CELL_LSB  = IN_BITS_LSB + BITS_W;
	localparam int unsigned IN_DATA_W    = 72;

	// Output tdata layout, lowest bit first.
	localparam int unsigned OUT_MASK_LSB  = 0;
	localparam int unsigned OUT_COLOR_LSB = OUT_MASK_LSB + BITS_W;
	localparam int unsigned OUT_ADDR_LSB  = OUT_COLOR_LSB + COLOR_W;
	localparam int unsigned OUT_DATA_W    = 48;

	// Decoded beat held in stage 1.
	typedef struct packed {
		logic               is_render;
		logic               wr_ok;
		logic               invalid;
		logic [GLYPH_W-1:0] glyph;
		logic [ROW_W-1:0]   row;
		logic [BITS_W-1:0]  font_bits;
		logic [COLOR_W-1:0] color;
	} dec_t;

	// Render beat side data held in stage 2 beside the font read data.
	typedef struct packed {
		logic               invalid;
		logic [INDEX_W-1:0] glyph_address;
		logic [COLOR_W-1:0] color;
	} rend_t;

endpackage

// ===== src/tmg_decode.sv =====
// Stage 1: unpacks the input beat and maps the cell's code bytes to a glyph number.
// Depends on tmg_pkg.
module tmg_decode #(
	parameter int unsigned GLYPH_COUNT = 16384
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tmg_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	output logic                             v_s1,
	output tmg_pkg::dec_t                    d_s1,
	input  logic                             rdy_s2
);

	logic                          take;
	logic [tmg_pkg::INDEX_W-1:0]   index;
	logic [tmg_pkg::ROW_W-1:0]     row;
	logic [tmg_pkg::BITS_W-1:0]    bits;
	logic [tmg_pkg::CELL_W-1:0]    cell_word;
	logic [7:0]                    code_hi;
	logic [7:0]                    code_lo;
	logic [tmg_pkg::GLYPH_W-1:0]   dbl_glyph;
	logic [tmg_pkg::GLYPH_W-1:0]   glyph;
	logic                          bad_code;
	logic                          beyond;
	tmg_pkg::dec_t                 dec;

	assign s_tready = !v_s1 || rdy_s2;
	assign take     = s_tvalid && s_tready;

	// Field unpacking.
	assign index     = s_tdata[tmg_pkg::IN_INDEX_LSB +: tmg_pkg::INDEX_W];
	assign row       = s_tdata[tmg_pkg::IN_ROW_LSB +: tmg_pkg::ROW_W];
	assign bits      = s_tdata[tmg_pkg::IN_BITS_LSB +: tmg_pkg::BITS_W];
	assign cell_word = s_tdata[tmg_pkg::IN_CELL_LSB +: tmg_pkg::CELL_W];
	assign code_hi   = cell_word[15:8];
	assign code_lo   = cell_word[7:0];

	// Double-byte glyph number; only used when both code bytes are nonzero.
	assign dbl_glyph = tmg_pkg::GLYPH_W'({8'd0, code_hi - 8'd1}
	                   * tmg_pkg::GLYPH_W'(tmg_pkg::CODES_PER_BANK))
	                 + tmg_pkg::GLYPH_W'({8'd0, code_lo - 8'd1})
	                 + tmg_pkg::GLYPH_W'(tmg_pkg::DOUBLE_BYTE_BASE);

	// Code classification and range check against the store size.
	always_comb begin
		bad_code = 1'b0;
		if (code_hi == 8'd0) begin
			glyph = tmg_pkg::GLYPH_W'(code_lo);
		end else if (code_lo == 8'd0) begin
			glyph    = '0;
			bad_code = 1'b1;
		end else begin
			glyph = dbl_glyph;
		end
		beyond = ({1'b0, glyph} >= 17'(GLYPH_COUNT));
	end

	// Decoded beat, common to writes and renders.
	always_comb begin
		dec.is_render = (s_tuser == tmg_pkg::REQ_RENDER);
		dec.wr_ok     = (17'(index) < 17'(GLYPH_COUNT));
		dec.row       = row;
		dec.font_bits = bits;
		dec.color     = cell_word[31:16];
		if (s_tuser == tmg_pkg::REQ_RENDER) begin
			dec.invalid = bad_code || beyond;
			dec.glyph   = (bad_code || beyond) ? '0 : glyph;
		end else begin
			dec.invalid = 1'b0;
			dec.glyph   = tmg_pkg::GLYPH_W'(index);
		end
	end

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= take;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (take) begin
			d_s1 <= dec;
		end
	end

endmodule

// ===== src/tmg_font_mem.sv =====
// Stage 2: the font store; writes rows and reads one row per render beat.
// Depends on tmg_pkg.
module tmg_font_mem #(
	parameter int unsigned GLYPH_COUNT = 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_s1,
	input  tmg_pkg::dec_t                  d_s1,
	output logic                           rdy_s2,
	output logic                           v_s2,
	output tmg_pkg::rend_t                 r_s2,
	output logic [tmg_pkg::BITS_W-1:0]     rd_s2,
	input  logic                           rdy_s3
);

	localparam int unsigned GW    = $clog2(GLYPH_COUNT);
	localparam int unsigned AW    = GW + tmg_pkg::ROW_W;
	localparam int unsigned DEPTH = GLYPH_COUNT * (2 ** tmg_pkg::ROW_W);

	logic [tmg_pkg::BITS_W-1:0] font_store [DEPTH];
	logic [AW-1:0]              addr;
	logic                       take;
	tmg_pkg::rend_t             rend;

	assign rdy_s2 = !v_s2 || rdy_s3;
	assign take   = v_s1 && rdy_s2;
	assign addr   = {d_s1.glyph[GW-1:0], d_s1.row};

	// Side data of a render beat.
	always_comb begin
		rend.invalid       = d_s1.invalid;
		rend.glyph_address = d_s1.glyph[tmg_pkg::INDEX_W-1:0];
		rend.color         = d_s1.color;
	end

	// Stage 2 valid bit; write beats end here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= take && d_s1.is_render;
		end
	end

	// Single-port font store: one write or one registered read per beat.
	always_ff @(posedge clk) begin
		if (take && !d_s1.is_render && d_s1.wr_ok) begin
			font_store[addr] <= d_s1.font_bits;
		end
		if (take && d_s1.is_render) begin
			rd_s2 <= font_store[addr];
			r_s2  <= rend;
		end
	end

endmodule

// ===== src/tmg_reorder.sv =====
// Stage 3: puts the glyph row into screen order and holds the output beat.
// Depends on tmg_pkg.
module tmg_reorder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_s2,
	input  tmg_pkg::rend_t                  r_s2,
	input  logic [tmg_pkg::BITS_W-1:0]      rd_s2,
	output logic                            rdy_s3,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tmg_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser
);

	logic                       take;
	logic [tmg_pkg::BITS_W-1:0] mask;

	assign rdy_s3 = !m_tvalid || m_tready;
	assign take   = v_s2 && rdy_s3;

	// Screen pixel k of each half takes bit (7 - k) of that byte.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			mask[k]     = rd_s2[7 - k];
			mask[8 + k] = rd_s2[15 - k];
		end
		if (r_s2.invalid) begin
			mask = '0;
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rdy_s3) begin
			m_tvalid <= take;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata <= {2'b00, r_s2.glyph_address, r_s2.color, mask};
			m_tuser <= r_s2.invalid;
		end
	end

endmodule

// ===== src/text_mode_glyph_row_generator_unit.sv =====
// Top level of the text-mode glyph row generator: decode, font store, reorder.
// Depends on tmg_pkg, tmg_decode, tmg_font_mem and tmg_reorder.
//
//   Channel  Direction  Beat contents
//   s_*      in         tuser: req_type; tdata: glyph_index, glyph_row, font_bits, cell_word
//   m_*      out        tuser: code_invalid; tdata: pixel_mask, pixel_color, glyph_address
//
// One beat is taken every cycle unless the output stalls; a render result passes through
// the three register stages in order: decode, font store read, reorder.
// Write beats update the font store in stage 2 and give no output beat.
// Reset clears the valid bits only; font store contents are undefined until written.
// Each stage holds while the stage after it is full and stalled; nothing is lost or repeated.
module text_mode_glyph_row_generator_unit #(
	parameter int unsigned GLYPH_COUNT = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [13:0] glyph_index, [17:14] glyph_row, [33:18] font_bits, [65:34] cell_word
	input  logic [tmg_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] req_type
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] pixel_mask, [31:16] pixel_color, [45:32] glyph_address
	output logic [tmg_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] code_invalid
	output logic                            m_tuser
);

	logic                        v_s1;
	tmg_pkg::dec_t               d_s1;
	logic                        rdy_s2;
	logic                        v_s2;
	tmg_pkg::rend_t              r_s2;
	logic [tmg_pkg::BITS_W-1:0]  rd_s2;
	logic                        rdy_s3;

	// Stage 1: unpack and code mapping.
	tmg_decode #(.GLYPH_COUNT(GLYPH_COUNT)) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.v_s1     (v_s1),
		.d_s1     (d_s1),
		.rdy_s2   (rdy_s2)
	);

	// Stage 2: font store access.
	tmg_font_mem #(.GLYPH_COUNT(GLYPH_COUNT)) u_font_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.rdy_s2 (rdy_s2),
		.v_s2   (v_s2),
		.r_s2   (r_s2),
		.rd_s2  (rd_s2),
		.rdy_s3 (rdy_s3)
	);

	// Stage 3: screen order and output register.
	tmg_reorder u_reorder (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.r_s2     (r_s2),
		.rd_s2    (rd_s2),
		.rdy_s3   (rdy_s3),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== src/tmg_checker.sv =====
// Port-level checks for the text-mode glyph row generator, bound to its top level.
// Depends on tmg_pkg and text_mode_glyph_row_generator_unit.
module tmg_checker #(
	parameter int unsigned GLYPH_COUNT = 16384
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tmg_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                            m_tuser
);

	// No output beat is offered while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat offered during reset");

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	// The input side only stalls when every stage is full and the output is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked output");

	// A blank result carries a zero mask and a zero glyph number.
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			m_tdata[tmg_pkg::OUT_MASK_LSB +: tmg_pkg::BITS_W] == '0 &&
			m_tdata[tmg_pkg::OUT_ADDR_LSB +: tmg_pkg::INDEX_W] == '0)
		else $error("blank result with nonzero mask or glyph");

	// A good result names a glyph inside the store.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			17'(m_tdata[tmg_pkg::OUT_ADDR_LSB +: tmg_pkg::INDEX_W]) < 17'(GLYPH_COUNT))
		else $error("glyph number beyond the store");

endmodule

bind text_mode_glyph_row_generator_unit tmg_checker #(.GLYPH_COUNT(GLYPH_COUNT)) u_tmg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/tmg_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the text-mode glyph row generator. It keeps a shadow font store,
// predicts every render result and compares the output beats. Depends on tmg_pkg.
module tmg_scoreboard #(
	parameter int unsigned GLYPH_COUNT = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [tmg_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [tmg_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                m_tuser,
	output int                                  mismatches,
	output int                                  outstanding
);

	localparam int unsigned ROWS_PER_GLYPH = 16;

	// One output beat split into its fields.
	typedef struct packed {
		logic [tmg_pkg::BITS_W-1:0]  mask;
		logic [tmg_pkg::COLOR_W-1:0] color;
		logic [tmg_pkg::INDEX_W-1:0] glyph_address;
		logic                        invalid;
	} glyph_row_t;

	// Shadow font rows, keyed by glyph * 16 + row; only written rows exist.
	logic [tmg_pkg::BITS_W-1:0] font_rows [int unsigned];
	glyph_row_t expected_rows [$];

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// Screen pixels 0..7 come from row bits 7..0, pixels 8..15 from bits 15..8.
	function automatic logic [tmg_pkg::BITS_W-1:0] screen_order(
			input logic [tmg_pkg::BITS_W-1:0] bits);
		logic [tmg_pkg::BITS_W-1:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = bits[7-k];
			r[8+k] = bits[15-k];
		end
		return r;
	endfunction

	// Work out the output beat that one render beat should produce.
	function automatic glyph_row_t predict_glyph_row(
			input logic [tmg_pkg::CELL_W-1:0] cell_word,
			input logic [tmg_pkg::ROW_W-1:0] row);
		glyph_row_t res;
		int unsigned hi;
		int unsigned lo;
		int unsigned glyph;
		hi = 32'(cell_word[15:8]);
		lo = 32'(cell_word[7:0]);
		res.color = cell_word[31:16];
		res.invalid = 1'b0;
		res.mask = '0;
		if (hi == 0) begin
			glyph = lo;
		end else if (lo == 0) begin
			// A double-byte code needs a nonzero low byte.
			glyph = 0;
			res.invalid = 1'b1;
		end else begin
			glyph = (hi - 1) * tmg_pkg::CODES_PER_BANK + (lo - 1) + tmg_pkg::DOUBLE_BYTE_BASE;
		end
		if (!res.invalid && glyph >= GLYPH_COUNT) begin
			glyph = 0;
			res.invalid = 1'b1;
		end
		if (!res.invalid)
			res.mask = screen_order(font_rows[glyph * ROWS_PER_GLYPH + 32'(row)]);
		res.glyph_address = glyph[tmg_pkg::INDEX_W-1:0];
		return res;
	endfunction

	// Compare result beats first, then take in the input beat of the same edge.
	always @(posedge clk) begin : watch
		glyph_row_t want;
		glyph_row_t got;
		int unsigned windex;
		int unsigned wrow;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.mask = m_tdata[tmg_pkg::OUT_MASK_LSB +: tmg_pkg::BITS_W];
				got.color = m_tdata[tmg_pkg::OUT_COLOR_LSB +: tmg_pkg::COLOR_W];
				got.glyph_address = m_tdata[tmg_pkg::OUT_ADDR_LSB +: tmg_pkg::INDEX_W];
				got.invalid = m_tuser;
				if (expected_rows.size() == 0) begin
					report_mismatch($sformatf("result beat with no render pending: %h",
						m_tdata));
				end else begin
					want = expected_rows.pop_front();
					if (got.mask !== want.mask)
						report_mismatch($sformatf("pixel_mask %h, expected %h",
							got.mask, want.mask));
					if (got.color !== want.color)
						report_mismatch($sformatf("pixel_color %h, expected %h",
							got.color, want.color));
					if (got.glyph_address !== want.glyph_address)
						report_mismatch($sformatf("glyph_address %0d, expected %0d",
							got.glyph_address, want.glyph_address));
					if (got.invalid !== want.invalid)
						report_mismatch($sformatf("code_invalid %b, expected %b",
							got.invalid, want.invalid));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == tmg_pkg::REQ_WRITE) begin
					windex = 32'(s_tdata[tmg_pkg::IN_INDEX_LSB +: tmg_pkg::INDEX_W]);
					wrow = 32'(s_tdata[tmg_pkg::IN_ROW_LSB +: tmg_pkg::ROW_W]);
					if (windex < GLYPH_COUNT)
						font_rows[windex * ROWS_PER_GLYPH + wrow] =
							s_tdata[tmg_pkg::IN_BITS_LSB +: tmg_pkg::BITS_W];
				end else begin
					expected_rows.push_back(predict_glyph_row(
						s_tdata[tmg_pkg::IN_CELL_LSB +: tmg_pkg::CELL_W],
						s_tdata[tmg_pkg::IN_ROW_LSB +: tmg_pkg::ROW_W]));
				end
			end
		end
		outstanding = expected_rows.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the glyph row generator testbench: clock, reset, font writes and render beats.
// Depends on tmg_pkg, text_mode_glyph_row_generator_unit and tmg_scoreboard.
module tb_top;

	localparam int unsigned GLYPHS = 16384;
	localparam int RANDOM_ITEMS = 1130;
	localparam int CALM_ITEMS = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [tmg_pkg::IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [tmg_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	int mismatches;
	int outstanding;

	// Idle control shared by the sender and the result stall process.
	logic calm = 1'b0;
	int gap_odds = 4;
	int stall_odds = 4;
	int stall_left = 0;

	// Keys (glyph * 16 + row) of every row written so far, oldest first.
	int unsigned written_keys [$];

	text_mode_glyph_row_generator_unit #(.GLYPH_COUNT(GLYPHS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	tmg_scoreboard #(.GLYPH_COUNT(GLYPHS)) u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [tmg_pkg::IN_DATA_W-1:0] pack_beat(
			input logic [tmg_pkg::INDEX_W-1:0] idx,
			input logic [tmg_pkg::ROW_W-1:0] row, input logic [tmg_pkg::BITS_W-1:0] bits,
			input logic [tmg_pkg::CELL_W-1:0] cell_word);
		logic [tmg_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[tmg_pkg::IN_INDEX_LSB +: tmg_pkg::INDEX_W] = idx;
		d[tmg_pkg::IN_ROW_LSB +: tmg_pkg::ROW_W] = row;
		d[tmg_pkg::IN_BITS_LSB +: tmg_pkg::BITS_W] = bits;
		d[tmg_pkg::IN_CELL_LSB +: tmg_pkg::CELL_W] = cell_word;
		return d;
	endfunction

	// Offer one beat, possibly after an idle burst, and wait until it is taken.
	task automatic push_beat(input logic kind, input logic [tmg_pkg::IN_DATA_W-1:0] data);
		int idle;
		if (!calm && gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
			idle = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic issue_write(input int unsigned glyph, input int unsigned row,
			input logic [tmg_pkg::BITS_W-1:0] bits);
		written_keys.push_back(glyph * 16 + row);
		push_beat(tmg_pkg::REQ_WRITE, pack_beat(glyph[tmg_pkg::INDEX_W-1:0],
			row[tmg_pkg::ROW_W-1:0], bits, $urandom()));
	endtask

	// The unused write fields of a render beat carry random bits.
	task automatic issue_render(input logic [tmg_pkg::CELL_W-1:0] cell_word,
			input logic [tmg_pkg::ROW_W-1:0] row);
		push_beat(tmg_pkg::REQ_RENDER, pack_beat(
			tmg_pkg::INDEX_W'($urandom_range(0, GLYPHS - 1)), row,
			tmg_pkg::BITS_W'($urandom_range(0, 65535)), cell_word));
	endtask

	// Render a row that was written, often one of the latest to hit the write path.
	task automatic render_written_row();
		int unsigned key;
		int unsigned glyph;
		int unsigned t;
		int unsigned h;
		int unsigned l;
		int unsigned k;
		int unsigned back;
		logic [tmg_pkg::COLOR_W-1:0] color;
		if ($urandom_range(1) == 0) begin
			back = (written_keys.size() > 4) ? 3 : written_keys.size() - 1;
			key = written_keys[written_keys.size() - 1 - $urandom_range(0, back)];
		end else begin
			key = written_keys[$urandom_range(0, written_keys.size() - 1)];
		end
		glyph = key / 16;
		if (glyph < tmg_pkg::DOUBLE_BYTE_BASE) begin
			h = 0;
			l = glyph;
		end else begin
			// Several code pairs reach the same glyph; pick one at random.
			t = glyph - tmg_pkg::DOUBLE_BYTE_BASE;
			h = t / tmg_pkg::CODES_PER_BANK + 1;
			l = t % tmg_pkg::CODES_PER_BANK + 1;
			k = $urandom_range(0, 2);
			while (k > 0 && (h <= k || l + tmg_pkg::CODES_PER_BANK * k > 255)) k--;
			h = h - k;
			l = l + tmg_pkg::CODES_PER_BANK * k;
		end
		color = tmg_pkg::COLOR_W'($urandom());
		issue_render({color, h[7:0], l[7:0]}, key[3:0]);
	endtask

	// A code that maps to no glyph: zero low byte, or a number past the store.
	task automatic render_bad_code();
		logic [7:0] h;
		logic [7:0] l;
		logic [tmg_pkg::COLOR_W-1:0] color;
		if ($urandom_range(1) == 0) begin
			h = 8'($urandom_range(1, 255));
			l = 8'd0;
		end else begin
			h = 8'($urandom_range(172, 255));
			l = (h == 8'd172) ? 8'($urandom_range(55, 255)) : 8'($urandom_range(1, 255));
		end
		color = tmg_pkg::COLOR_W'($urandom());
		issue_render({color, h, l}, tmg_pkg::ROW_W'($urandom_range(0, 15)));
	endtask

	function automatic int unsigned hot_glyph();
		case ($urandom_range(2))
			0: return $urandom_range(0, 31);
			1: return $urandom_range(240, 271);
			default: return $urandom_range(GLYPHS - 32, GLYPHS - 1);
		endcase
	endfunction

	// Result side stalls in bursts; none once the run has gone calm.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 15);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = tmg_pkg::REQ_WRITE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: corner glyphs, both code forms and each bad-code case.
		issue_write(0, 0, 16'h0001);
		issue_write(255, 15, 16'h8000);
		issue_write(256, 3, 16'hffff);
		issue_write(GLYPHS - 1, 15, 16'ha5c3);
		issue_write(1000, 7, 16'h0f1e);
		issue_render({16'hffff, 8'd0, 8'd0}, 4'd0);
		issue_render({16'h0000, 8'd0, 8'd255}, 4'd15);
		issue_render({16'h1234, 8'd1, 8'd1}, 4'd3);
		issue_render({16'h8001, 8'd172, 8'd54}, 4'd15);
		issue_render({16'h5a5a, 8'd8, 8'd87}, 4'd7);
		issue_render({16'h7fff, 8'd7, 8'd181}, 4'd7);
		issue_render({16'hc3c3, 8'd172, 8'd55}, 4'd15);
		issue_render({16'h0f0f, 8'd255, 8'd255}, 4'd0);
		issue_render({16'hf0f0, 8'h80, 8'h00}, 4'd9);
		// Overwrite a row and read it back on the very next beat.
		issue_write(0, 0, 16'hfffe);
		issue_render({16'h00ff, 8'd0, 8'd0}, 4'd0);

		// Random part: writes to a hot set and anywhere, renders of written rows, bad codes.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				gap_odds = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 10);
				stall_odds = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 10);
			end
			if (i >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				if ($urandom_range(0, 9) < 6)
					issue_write(hot_glyph(), $urandom_range(0, 15),
						tmg_pkg::BITS_W'($urandom()));
				else
					issue_write($urandom_range(0, GLYPHS - 1), $urandom_range(0, 15),
						tmg_pkg::BITS_W'($urandom()));
			end else if (pick < 85) begin
				render_written_row();
			end else begin
				render_bad_code();
			end
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
